// ===== src/ihs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihs_pkg: shared types and constants of the implicit heat step block
// Rod size, register codes, controller states and the command/status bundles
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ihs_pkg;

  // rod geometry
  localparam int INTERVALS = 1024;
  localparam int NODES     = INTERVALS + 1;
  localparam int IDX_W     = $clog2(NODES);
  localparam int AB_W      = $clog2(INTERVALS);

  // datapath widths
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int PROBE_W   = 11;
  localparam int D_W       = 34;  // divisor 2^24 + 2r - ra
  localparam int Q_W       = 40;  // quotient bits produced by the divider
  localparam int DCNT_W    = $clog2(Q_W + 1);

  // register reset values
  localparam logic [DATA_W-1:0]        RATIO_RST = 32'd21198816;
  localparam logic signed [DATA_W-1:0] BOUND_RST = -32'sd6553600;
  localparam logic signed [DATA_W-1:0] INIT_RST  = 32'sd1310720;
  localparam logic [PROBE_W-1:0]       PROBE_RST = 11'd512;

  localparam logic signed [DATA_W-1:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] T_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATIO = 2'd0,
    REG_BOUND = 2'd1,
    REG_INIT  = 2'd2,
    REG_PROBE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    NW_RESET,
    NW_INIT,
    NW_BOUND,
    NW_BACK
  } node_wsel_e;

  typedef enum logic [1:0] {
    MUL_RA,
    MUL_BETA,
    MUL_BACK
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_F_INIT,
    ST_F_RA,
    ST_F_D,
    ST_F_M,
    ST_F_DIV,
    ST_F_WR,
    ST_B_TOP,
    ST_B_RD,
    ST_B_MUL,
    ST_B_WR,
    ST_P_RD,
    ST_OUT
  } state_e;

  // sequencer to datapath
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             node_we;
    node_wsel_e       node_wsel;
    logic             node_rd;
    logic             probe_rd;
    logic             ab_we;
    logic             ab_init;
    logic             ab_rd;
    logic             mul_en;
    mul_sel_e         mul_sel;
    logic             d_en;
    logic             div_start;
    logic             t_bound;
    logic             t_back;
    logic             steps_clr;
    logic             steps_inc;
    logic             out_load;
  } cmd_t;

  // datapath to sequencer
  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

  // magnitude of a signed word as unsigned
  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
    mag32 = x[DATA_W-1] ? (~x + 32'd1) : x;
  endfunction

endpackage
`default_nettype wire

// ===== src/ihs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihs_div: restoring divider, one quotient bit per cycle
// Divides a 64-bit dividend whose quotient fits in Q_W bits by a D_W-bit
// divisor; leaves quotient and remainder stable after the done pulse.
// ----------------------------------------------------------------------------
module ihs_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [63:0]                   dividend_i,
  input  wire [ihs_pkg::D_W-1:0]       divisor_i,
  output logic                         done_o,
  output logic [ihs_pkg::Q_W-1:0]      quot_o,
  output logic [ihs_pkg::D_W-1:0]      rem_o
);
  import ihs_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [D_W-1:0]    rem_q;
  logic [Q_W-1:0]    sh_q;
  logic [D_W:0]      trial;
  logic              fits;

  // trial subtraction of one step
  always_comb begin
    trial = {rem_q, sh_q[Q_W-1]};
    fits  = trial >= {1'b0, divisor_i};
  end

  // control: busy flag, step count, finish pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(Q_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= D_W'(dividend_i[63:Q_W]);
      sh_q  <= dividend_i[Q_W-1:0];
    end else if (busy_q) begin
      rem_q <= fits ? D_W'(trial - {1'b0, divisor_i}) : trial[D_W-1:0];
      sh_q  <= {sh_q[Q_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== src/ihs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihs_datapath: registers, node/sweep memories, multiplier and dividers
// Executes the commands of the sequencer for the forward sweep, the back
// substitution, node fills and the probe report.
// ----------------------------------------------------------------------------
module ihs_datapath (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [ihs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [ihs_pkg::DATA_W-1:0]       cfg_data_i,
  input  ihs_pkg::cmd_t                   cmd_i,
  output ihs_pkg::sts_t                   sts_o,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic signed [ihs_pkg::DATA_W-1:0] probe_temp_o,
  output logic [ihs_pkg::DATA_W-1:0]      steps_done_o
);
  import ihs_pkg::*;

  // configuration registers
  logic [DATA_W-1:0]        ratio_q;
  logic signed [DATA_W-1:0] bound_q;
  logic signed [DATA_W-1:0] init_q;
  logic [PROBE_W-1:0]       probe_q;

  // memories
  logic [DATA_W-1:0] node_mem  [NODES];
  logic [DATA_W-1:0] alpha_mem [INTERVALS];
  logic [DATA_W-1:0] beta_mem  [INTERVALS];

  logic [DATA_W-1:0] node_rd_q, alpha_rd_q, beta_rd_q;
  logic [DATA_W-1:0] alpha_prev_q, beta_prev_q, t_next_q;
  logic [63:0]       prod_q;
  logic [D_W-1:0]    d_q;
  logic              neg_q;
  logic [DATA_W-1:0] steps_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] probe_temp_q, steps_done_q;

  logic [IDX_W-1:0]  probe_c, node_raddr;
  logic [DATA_W-1:0] node_wdata, ab_wa, ab_wb;
  logic [DATA_W-1:0] ma, mb;
  logic [64:0]       ra_sum, bk_sum;
  logic [32:0]       ra, rm;
  logic [D_W:0]      d_calc;
  logic [63:0]       pm, qm, m_c;
  logic              pn, qn, m_neg;
  logic              div_a_done, div_b_done;
  logic [Q_W-1:0]    quot_a, quot_b;
  logic [D_W-1:0]    rem_a, rem_b;
  logic              up_a, up_b;
  logic [Q_W:0]      qb;
  logic [DATA_W-1:0] alpha_new, beta_new, back_val;
  logic signed [D_W:0] v35, sum35;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RATIO_RST;
      bound_q <= BOUND_RST;
      init_q  <= INIT_RST;
      probe_q <= PROBE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RATIO: ratio_q <= cfg_data_i;
        REG_BOUND: bound_q <= cfg_data_i;
        REG_INIT:  init_q  <= cfg_data_i;
        REG_PROBE: probe_q <= cfg_data_i[PROBE_W-1:0];
        default: ;
      endcase
    end
  end

  // probe index clamp and node port selects
  always_comb begin
    probe_c    = (probe_q > PROBE_W'(INTERVALS)) ? IDX_W'(INTERVALS)
                                                 : IDX_W'(probe_q);
    node_raddr = cmd_i.probe_rd ? probe_c : cmd_i.idx;
    case (cmd_i.node_wsel)
      NW_RESET: node_wdata = INIT_RST;
      NW_INIT:  node_wdata = init_q;
      NW_BOUND: node_wdata = bound_q;
      default:  node_wdata = back_val;
    endcase
  end

  // node memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.node_we) node_mem[cmd_i.idx] <= node_wdata;
    if (cmd_i.node_rd) node_rd_q <= node_mem[node_raddr];
  end

  // sweep coefficient memories
  assign ab_wa = cmd_i.ab_init ? '0 : alpha_new;
  assign ab_wb = cmd_i.ab_init ? bound_q : beta_new;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ab_we) begin
      alpha_mem[cmd_i.idx[AB_W-1:0]] <= ab_wa;
      beta_mem[cmd_i.idx[AB_W-1:0]]  <= ab_wb;
      alpha_prev_q <= ab_wa;
      beta_prev_q  <= ab_wb;
    end
    if (cmd_i.ab_rd) begin
      alpha_rd_q <= alpha_mem[cmd_i.idx[AB_W-1:0]];
      beta_rd_q  <= beta_mem[cmd_i.idx[AB_W-1:0]];
    end
  end

  // shared multiplier, registered product
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_RA:   begin ma = ratio_q;    mb = alpha_prev_q;       end
      MUL_BETA: begin ma = ratio_q;    mb = mag32(beta_prev_q); end
      MUL_BACK: begin ma = alpha_rd_q; mb = mag32(t_next_q);    end
      default:  begin ma = ratio_q;    mb = alpha_prev_q;       end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= 64'(ma) * 64'(mb);
  end

  // diagonal term d = 1 + 2r - round(r*alpha)
  always_comb begin
    ra_sum = {1'b0, prod_q} + 65'h0_8000_0000;
    ra     = ra_sum[64:32];
    d_calc = (D_W+1)'(1 << 24) + (D_W+1)'({ratio_q, 1'b0}) - (D_W+1)'(ra);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.d_en) d_q <= d_calc[D_W-1:0];
  end

  // beta numerator in sign/magnitude form
  always_comb begin
    pm = prod_q;
    qm = {8'd0, mag32(node_rd_q), 24'd0};
    pn = beta_prev_q[DATA_W-1];
    qn = node_rd_q[DATA_W-1];
    if (pn == qn) begin
      m_c = pm + qm; m_neg = pn;
    end else if (pm >= qm) begin
      m_c = pm - qm; m_neg = pn;
    end else begin
      m_c = qm - pm; m_neg = qn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) neg_q <= m_neg;
  end

  ihs_div u_div_alpha (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({ratio_q, 32'd0}),
    .divisor_i  (d_q),
    .done_o     (div_a_done),
    .quot_o     (quot_a),
    .rem_o      (rem_a)
  );

  ihs_div u_div_beta (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (m_c),
    .divisor_i  (d_q),
    .done_o     (div_b_done),
    .quot_o     (quot_b),
    .rem_o      (rem_b)
  );

  // round half up, saturate beta
  always_comb begin
    up_a      = {rem_a, 1'b0} >= {1'b0, d_q};
    up_b      = {rem_b, 1'b0} >= {1'b0, d_q};
    alpha_new = quot_a[DATA_W-1:0] + DATA_W'(up_a);
    qb        = {1'b0, quot_b} + (Q_W+1)'(up_b);
    if (neg_q) begin
      beta_new = (qb > (Q_W+1)'(33'h0_8000_0000)) ? T_MIN : (~qb[DATA_W-1:0] + 32'd1);
    end else begin
      beta_new = (qb > (Q_W+1)'(33'h0_7FFF_FFFF)) ? T_MAX : qb[DATA_W-1:0];
    end
  end

  // back substitution: T = sat(round(alpha*T_next) + beta)
  always_comb begin
    bk_sum = {1'b0, prod_q} + 65'h0_8000_0000;
    rm     = bk_sum[64:32];
    v35    = t_next_q[DATA_W-1] ? -$signed({2'b00, rm}) : $signed({2'b00, rm});
    sum35  = v35 + (D_W+1)'($signed(beta_rd_q));
    if (sum35 > (D_W+1)'(T_MAX))      back_val = T_MAX;
    else if (sum35 < (D_W+1)'(T_MIN)) back_val = T_MIN;
    else                              back_val = sum35[DATA_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.t_bound)     t_next_q <= bound_q;
    else if (cmd_i.t_back) t_next_q <= back_val;
  end

  // step counter, saturating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
    end else if (cmd_i.steps_clr) begin
      steps_q <= '0;
    end else if (cmd_i.steps_inc && (steps_q != '1)) begin
      steps_q <= steps_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      probe_temp_q <= node_rd_q;
      steps_done_q <= steps_q;
    end
  end

  assign sts_o.div_done = div_a_done & div_b_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign probe_temp_o   = probe_temp_q;
  assign steps_done_o   = steps_done_q;

`ifndef SYNTHESIS
  a_div_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_a_done == div_b_done)
    else $error("dividers out of step");
`endif

endmodule
`default_nettype wire

// ===== src/ihs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihs_ctrl: sequencer of the implicit heat step
// Walks the clearing pass, restart fill, forward sweep, back substitution
// and probe report, and drives the datapath commands.
// ----------------------------------------------------------------------------
module ihs_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  input  wire            restart_i,
  output logic           in_stall_o,
  input  ihs_pkg::sts_t  sts_i,
  output ihs_pkg::cmd_t  cmd_o
);
  import ihs_pkg::*;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // next state and node index
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (idx_q == IDX_W'(INTERVALS)) begin
          state_d = ST_IDLE;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        idx_d = '0;
        if (in_valid_i) state_d = restart_i ? ST_FILL : ST_F_INIT;
      end
      ST_FILL: begin
        if (idx_q == IDX_W'(INTERVALS)) state_d = ST_P_RD;
        else                            idx_d   = idx_q + 1'b1;
      end
      ST_F_INIT: begin
        state_d = ST_F_RA;
        idx_d   = IDX_W'(1);
      end
      ST_F_RA:  state_d = ST_F_D;
      ST_F_D:   state_d = ST_F_M;
      ST_F_M:   state_d = ST_F_DIV;
      ST_F_DIV: if (sts_i.div_done) state_d = ST_F_WR;
      ST_F_WR: begin
        if (idx_q == IDX_W'(INTERVALS - 1)) begin
          state_d = ST_B_TOP;
          idx_d   = IDX_W'(INTERVALS);
        end else begin
          state_d = ST_F_RA;
          idx_d   = idx_q + 1'b1;
        end
      end
      ST_B_TOP: begin
        state_d = ST_B_RD;
        idx_d   = IDX_W'(INTERVALS - 1);
      end
      ST_B_RD:  state_d = ST_B_MUL;
      ST_B_MUL: state_d = ST_B_WR;
      ST_B_WR: begin
        if (idx_q == '0) begin
          state_d = ST_P_RD;
        end else begin
          state_d = ST_B_RD;
          idx_d   = idx_q - 1'b1;
        end
      end
      ST_P_RD: state_d = ST_OUT;
      ST_OUT:  if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.idx       = idx_q;
    cmd_o.node_wsel = NW_BACK;
    cmd_o.mul_sel   = MUL_RA;
    in_stall_o      = (state_q != ST_IDLE);
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.node_we   = 1'b1;
        cmd_o.node_wsel = NW_RESET;
      end
      ST_IDLE: begin
        cmd_o.steps_clr = in_valid_i && restart_i;
      end
      ST_FILL: begin
        cmd_o.node_we   = 1'b1;
        cmd_o.node_wsel = NW_INIT;
      end
      ST_F_INIT: begin
        cmd_o.ab_we   = 1'b1;
        cmd_o.ab_init = 1'b1;
      end
      ST_F_RA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RA;
        cmd_o.node_rd = 1'b1;
      end
      ST_F_D: begin
        cmd_o.d_en    = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BETA;
      end
      ST_F_M:   cmd_o.div_start = 1'b1;
      ST_F_DIV: ;
      ST_F_WR:  cmd_o.ab_we = 1'b1;
      ST_B_TOP: begin
        cmd_o.node_we   = 1'b1;
        cmd_o.node_wsel = NW_BOUND;
        cmd_o.t_bound   = 1'b1;
        cmd_o.steps_inc = 1'b1;
      end
      ST_B_RD: cmd_o.ab_rd = 1'b1;
      ST_B_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BACK;
      end
      ST_B_WR: begin
        cmd_o.node_we   = 1'b1;
        cmd_o.node_wsel = NW_BACK;
        cmd_o.t_back    = 1'b1;
      end
      ST_P_RD: begin
        cmd_o.node_rd  = 1'b1;
        cmd_o.probe_rd = 1'b1;
      end
      ST_OUT:  cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == ST_F_DIV))
    else $error("divider started outside the sweep");
  a_ab_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.ab_we || cmd_o.ab_rd) |-> (idx_q < IDX_W'(INTERVALS)))
    else $error("sweep memory index out of range");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result overwritten while stalled");
  a_top_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_B_TOP) |-> (idx_q == IDX_W'(INTERVALS)))
    else $error("boundary written to wrong node");
`endif

endmodule
`default_nettype wire

// ===== src/implicit_heat_step_tridiagonal.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// implicit_heat_step_tridiagonal: 1-D rod, one implicit time step per non-restart request
// Backward-Euler heat step solved by the Thomas algorithm over 1025 nodes;
// reports the probe node temperature and the step count per request.
//
//   channel   signals                             direction
//   config    cfg_we_i, cfg_idx_i, cfg_data_i     in, write only
//   request   in_valid_i, in_stall_o, restart_i   in
//   result    out_valid_o, out_stall_i,
//             probe_temp_o, steps_done_o          out
//
// Each forward node of a time step waits on the bit-serial dividers; a
// restart request instead refills the nodes, one write a cycle.
// After reset a clearing pass loads the nodes.
// A request is taken only while idle; a held result does not block the next
// request, whose result then waits in ST_OUT until the held one is taken.
// ----------------------------------------------------------------------------
module implicit_heat_step_tridiagonal (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [ihs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [ihs_pkg::DATA_W-1:0]         cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire                               restart_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [ihs_pkg::DATA_W-1:0] probe_temp_o,
  output logic [ihs_pkg::DATA_W-1:0]        steps_done_o
);
  import ihs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ihs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ihs_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .probe_temp_o (probe_temp_o),
    .steps_done_o (steps_done_o)
  );

endmodule
`default_nettype wire
